// File: design/dsjtq_pkg.sv
// shared types and constants for the deadline-sorted job timer queue
// no dependencies; used by deadline_sorted_job_timer_queue
`default_nettype none

package dsjtq_pkg;

   // request kinds carried on req_tuser
   localparam logic OP_SCHEDULE = 1'b0;
   localparam logic OP_POLL     = 1'b1;

   // result status codes carried on rsp_tuser
   localparam logic [1:0] ST_SCHEDULED = 2'd0;
   localparam logic [1:0] ST_NO_SLOT   = 2'd1;
   localparam logic [1:0] ST_FIRED     = 2'd2;
   localparam logic [1:0] ST_NONE_DUE  = 2'd3;

   // request tdata layout, lowest bit first
   localparam int NOW_LSB    = 0;
   localparam int TAG_LSB    = 32;
   localparam int REP_LSB    = 40;
   localparam int DELAY_LSB  = 41;
   localparam int PERIOD_LSB = 73;
   localparam int REQ_DATA_W = 112;

   // one queued job as stored in the job memory
   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] period;
      logic [7:0]  tag;
      logic        repeating;
   } job_rec_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_INS_START,
      S_INS_CMP,
      S_INS_LAST,
      S_RESP
   } state_type;

   // saturating 32-bit add
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

`default_nettype wire

// File: design/deadline_sorted_job_timer_queue.sv
// deadline-sorted job timer queue, top level
// depends on dsjtq_pkg for the job record, state type and status codes
`default_nettype none

// Software-style timer list in hardware. Each request is a schedule or a poll and carries
// the current time in ms. A schedule stores the job with deadline = now + delay (saturating)
// and inserts it ahead of any jobs with an equal deadline; when MAX_JOBS jobs are queued it
// reports no free slot. A poll removes the head job if its deadline is at or before now and
// reports its tag; a repeating job gets deadline + period (saturating) and is inserted again.
// Every request yields exactly one response. Jobs sit in one single-port-write, registered-read
// memory kept as a circular buffer sorted by deadline; an insert walks from the tail toward
// the head, one queued job per cycle, moving each later job up by one entry. A refused schedule
// or a poll of an empty list goes straight to the response state; a poll otherwise reads the
// head first, and a schedule or a poll that fires a repeating job then walks the memory, so
// its time grows with the jobs queued. A new request is taken while the previous response
// still waits on the rsp side; a stalled rsp side holds the block in its response state
// until that response is taken.

module deadline_sorted_job_timer_queue #(
   parameter int MAX_JOBS = 16
) (
   input  wire          clock,
   input  wire          reset,
   // request channel
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [111:0] req_tdata,  // now_ms[31:0], job_tag[39:32], repeating[40],
                                    // lead_ms[72:41], period_ms[104:73], zero fill
   input  wire          req_tuser,  // opcode: 0 schedule, 1 poll
   // response channel
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [7:0]   rsp_tdata,  // fired_tag[7:0]
   output logic [1:0]   rsp_tuser   // status[1:0]
);

   localparam int SW = $clog2(MAX_JOBS);       // slot / position index width
   localparam int CW = $clog2(MAX_JOBS + 1);   // queued count width
   localparam logic [SW-1:0] LAST_POS = SW'(MAX_JOBS - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_JOBS);
   localparam logic [CW:0]   N_WIDE   = (CW + 1)'(MAX_JOBS);

   // job memory, circular buffer ordered by deadline from head_ff
   dsjtq_pkg::job_rec_type job_mem [MAX_JOBS];

   dsjtq_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SW-1:0]          head_ff, head_in;
   logic [SW-1:0]          rd_ptr_ff, rd_ptr_in;   // position being compared
   logic [SW-1:0]          wr_ptr_ff, wr_ptr_in;   // hole one above it
   logic [CW-1:0]          remain_ff, remain_in;   // jobs still below the hole
   dsjtq_pkg::job_rec_type new_rec_ff, new_rec_in;
   logic [31:0]            now_ff, now_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [7:0]             res_tag_ff, res_tag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_tag_ff, rsp_tag_in;
   dsjtq_pkg::job_rec_type rd_data_ff;

   // memory port controls
   logic [SW-1:0]          rd_addr;
   logic                   mem_we;
   logic [SW-1:0]          mem_wa;
   dsjtq_pkg::job_rec_type mem_wd;

   // request fields
   logic                   req_op;
   logic [31:0]            req_now;
   logic [7:0]             req_tag;
   logic                   req_rep;
   logic [31:0]            req_delay;
   logic [31:0]            req_period;

   // derived control
   logic                   req_take;
   logic                   rsp_free;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   head_due;
   logic                   move_up;
   logic [SW-1:0]          tail_pos;      // head + count, wrapped
   logic [SW-1:0]          last_pos;      // head + count - 1, wrapped
   logic [SW-1:0]          rd_ptr_dec;
   logic [SW-1:0]          head_inc;
   logic [CW:0]            tail_sum;
   logic [CW:0]            last_sum;

   assign req_op     = req_tuser;
   assign req_now    = req_tdata[dsjtq_pkg::NOW_LSB +: 32];
   assign req_tag    = req_tdata[dsjtq_pkg::TAG_LSB +: 8];
   assign req_rep    = req_tdata[dsjtq_pkg::REP_LSB];
   assign req_delay  = req_tdata[dsjtq_pkg::DELAY_LSB +: 32];
   assign req_period = req_tdata[dsjtq_pkg::PERIOD_LSB +: 32];

   assign req_tready  = (state_ff == dsjtq_pkg::S_IDLE);
   assign req_take    = req_tvalid && req_tready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign queue_full  = (count_ff == FULL_CNT);
   assign queue_empty = (count_ff == '0);
   // head job is due when its deadline is not after now
   assign head_due    = !(rd_data_ff.deadline > now_ff);
   // stored job goes behind the new one when its deadline is equal or later
   assign move_up     = (rd_data_ff.deadline >= new_rec_ff.deadline);

   // circular position arithmetic, sums stay below twice the depth
   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign last_sum = tail_sum - (CW + 1)'(1);
   assign tail_pos = (tail_sum >= N_WIDE) ? SW'(tail_sum - N_WIDE) : SW'(tail_sum);
   assign last_pos = (last_sum >= N_WIDE) ? SW'(last_sum - N_WIDE) : SW'(last_sum);
   assign rd_ptr_dec = (rd_ptr_ff == '0) ? LAST_POS : rd_ptr_ff - SW'(1);
   assign head_inc   = (head_ff == LAST_POS) ? '0 : head_ff + SW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsjtq_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_op == dsjtq_pkg::OP_SCHEDULE) begin
                  state_in = queue_full ? dsjtq_pkg::S_RESP : dsjtq_pkg::S_INS_START;
               end else begin
                  state_in = queue_empty ? dsjtq_pkg::S_RESP : dsjtq_pkg::S_HEAD;
               end
            end
         end
         dsjtq_pkg::S_HEAD: begin
            if (head_due && rd_data_ff.repeating) begin
               state_in = dsjtq_pkg::S_INS_START;
            end else begin
               state_in = dsjtq_pkg::S_RESP;
            end
         end
         dsjtq_pkg::S_INS_START: begin
            state_in = queue_empty ? dsjtq_pkg::S_RESP : dsjtq_pkg::S_INS_CMP;
         end
         dsjtq_pkg::S_INS_CMP: begin
            if (!move_up) begin
               state_in = dsjtq_pkg::S_RESP;
            end else if (remain_ff == CW'(1)) begin
               state_in = dsjtq_pkg::S_INS_LAST;
            end
         end
         dsjtq_pkg::S_INS_LAST: begin
            state_in = dsjtq_pkg::S_RESP;
         end
         dsjtq_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = dsjtq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dsjtq_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      remain_in     = remain_ff;
      new_rec_in    = new_rec_ff;
      now_in        = now_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rd_addr       = rd_ptr_ff;
      mem_we        = 1'b0;
      mem_wa        = wr_ptr_ff;
      mem_wd        = new_rec_ff;
      case (state_ff)
         dsjtq_pkg::S_IDLE: begin
            // head read is issued here so a poll sees it next cycle
            rd_addr = head_ff;
            if (req_take) begin
               now_in     = req_now;
               res_tag_in = '0;
               if (req_op == dsjtq_pkg::OP_SCHEDULE) begin
                  res_status_in = queue_full ? dsjtq_pkg::ST_NO_SLOT
                                             : dsjtq_pkg::ST_SCHEDULED;
                  new_rec_in.deadline  = dsjtq_pkg::sat_add32(req_now, req_delay);
                  new_rec_in.period    = req_period;
                  new_rec_in.tag       = req_tag;
                  new_rec_in.repeating = req_rep;
               end else begin
                  res_status_in = dsjtq_pkg::ST_NONE_DUE;
               end
            end
         end
         dsjtq_pkg::S_HEAD: begin
            if (head_due) begin
               res_status_in = dsjtq_pkg::ST_FIRED;
               res_tag_in    = rd_data_ff.tag;
               head_in       = head_inc;
               count_in      = count_ff - CW'(1);
               // repeating job comes back with its next deadline
               new_rec_in.deadline  = dsjtq_pkg::sat_add32(rd_data_ff.deadline,
                                                           rd_data_ff.period);
               new_rec_in.period    = rd_data_ff.period;
               new_rec_in.tag       = rd_data_ff.tag;
               new_rec_in.repeating = rd_data_ff.repeating;
            end
         end
         dsjtq_pkg::S_INS_START: begin
            if (queue_empty) begin
               mem_we   = 1'b1;
               mem_wa   = head_ff;
               count_in = count_ff + CW'(1);
            end else begin
               // start the walk at the tail job
               rd_addr   = last_pos;
               rd_ptr_in = last_pos;
               wr_ptr_in = tail_pos;
               remain_in = count_ff;
            end
         end
         dsjtq_pkg::S_INS_CMP: begin
            mem_we = 1'b1;
            if (move_up) begin
               // shift the later job one place toward the tail
               mem_wd    = rd_data_ff;
               wr_ptr_in = rd_ptr_ff;
               rd_ptr_in = rd_ptr_dec;
               rd_addr   = rd_ptr_dec;
               remain_in = remain_ff - CW'(1);
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         dsjtq_pkg::S_INS_LAST: begin
            // new job becomes the head entry
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
         end
         dsjtq_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tag_in    = res_tag_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsjtq_pkg::S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      remain_ff     <= remain_in;
      new_rec_ff    <= new_rec_in;
      now_ff        <= now_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   // job memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= job_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tag_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// File: bench/tb_deadline_sorted_job_timer_queue.sv
// self-checking bench for deadline_sorted_job_timer_queue: directed table, then random traffic
// depends on dsjtq_pkg and the rtl top; holds its own model of the sorted job list

module tb_deadline_sorted_job_timer_queue;

   localparam int MAX_JOBS   = 16;
   localparam int ORDER_W    = $clog2(MAX_JOBS);
   localparam int QUIET_MAX  = 2000;  // cycles with no handshake before giving up
   localparam int PHASE_LEN  = 310;
   localparam int PHASES     = 5;

   // one request, plus an optional hand-written response
   typedef struct packed {
      logic        op;
      logic [31:0] now;
      logic [7:0]  tag;
      logic        rep;
      logic [31:0] dly;
      logic [31:0] per;
      logic        typed;   // use st/ftag below instead of the model
      logic [1:0]  st;
      logic [7:0]  ftag;
   } timer_row_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] tag;
   } timer_outcome_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // now, tag, repeating, delay, period, zero fill
   logic [dsjtq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser  = dsjtq_pkg::OP_SCHEDULE;  // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;  // fired_tag
   logic [1:0]            rsp_tuser;  // status

   // bench control
   logic idling     = 1'b1;
   int   faults     = 0;
   int   quiet_run  = 0;
   int   sink_stall = 0;

   // model of the job list
   logic [31:0]        job_deadline [MAX_JOBS];
   logic [31:0]        job_period   [MAX_JOBS];
   logic [7:0]         job_tag_mem  [MAX_JOBS];
   logic               job_repeats  [MAX_JOBS];
   logic [ORDER_W-1:0] deadline_order [MAX_JOBS];
   int                 job_count = 0;
   logic [MAX_JOBS-1:0] slot_free = '1;

   timer_outcome_type outcome_fifo [$];
   timer_row_type     opening_rows [25];

   deadline_sorted_job_timer_queue #(
      .MAX_JOBS(MAX_JOBS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // deadline arithmetic clamps at the top of the time range
   function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[32] ? 32'hFFFF_FFFF : wide[31:0];
   endfunction

   // put a slot in deadline order, in front of any equal deadline
   function automatic void file_by_deadline(input int slot);
      int pos;
      pos = 0;
      while (pos < job_count && job_deadline[deadline_order[pos]] < job_deadline[slot])
         pos++;
      for (int i = job_count; i > pos; i--)
         deadline_order[i] = deadline_order[i - 1];
      deadline_order[pos] = slot[ORDER_W-1:0];
      job_count++;
   endfunction

   // apply one request to the model and return the response it should produce
   function automatic timer_outcome_type advance_timer_list(input timer_row_type r);
      timer_outcome_type o;
      int slot;
      int head;
      o.status = dsjtq_pkg::ST_NONE_DUE;
      o.tag    = '0;
      if (r.op == dsjtq_pkg::OP_SCHEDULE) begin
         slot = -1;
         for (int i = MAX_JOBS - 1; i >= 0; i--)
            if (slot_free[i]) slot = i;
         if (slot < 0 || job_count >= MAX_JOBS) begin
            o.status = dsjtq_pkg::ST_NO_SLOT;
         end else begin
            slot_free[slot]    = 1'b0;
            job_deadline[slot] = clamp_sum(r.now, r.dly);
            job_period[slot]   = r.per;
            job_tag_mem[slot]  = r.tag;
            job_repeats[slot]  = r.rep;
            file_by_deadline(slot);
            o.status = dsjtq_pkg::ST_SCHEDULED;
         end
      end else if (job_count != 0 && job_deadline[deadline_order[0]] <= r.now) begin
         head = int'(deadline_order[0]);
         for (int i = 1; i < job_count; i++)
            deadline_order[i - 1] = deadline_order[i];
         job_count--;
         o.status = dsjtq_pkg::ST_FIRED;
         o.tag    = job_tag_mem[head];
         if (job_repeats[head]) begin
            job_deadline[head] = clamp_sum(job_deadline[head], job_period[head]);
            file_by_deadline(head);
         end else begin
            slot_free[head] = 1'b1;
         end
      end
      return o;
   endfunction

   // present one request, wait for the handshake, then log what should come back
   task automatic offer_request(input timer_row_type r);
      logic [dsjtq_pkg::REQ_DATA_W-1:0] pkt;
      timer_outcome_type                want;
      pkt = '0;
      pkt[dsjtq_pkg::NOW_LSB +: 32]    = r.now;
      pkt[dsjtq_pkg::TAG_LSB +: 8]     = r.tag;
      pkt[dsjtq_pkg::REP_LSB]          = r.rep;
      pkt[dsjtq_pkg::DELAY_LSB +: 32]  = r.dly;
      pkt[dsjtq_pkg::PERIOD_LSB +: 32] = r.per;
      // sender gap burst
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pkt;
      req_tuser  <= r.op;
      do @(posedge clock); while (!req_tready);
      want = advance_timer_list(r);
      if (r.typed) begin
         want.status = r.st;
         want.tag    = r.ftag;
      end
      outcome_fifo.push_back(want);
   endtask

   // response side: ready drops in random bursts while idling is on
   always @(posedge clock) begin
      if (sink_stall != 0) begin
         sink_stall <= sink_stall - 1;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         sink_stall <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare every accepted response with the oldest outstanding one
   always @(posedge clock) begin : rsp_check
      timer_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_fifo.size() == 0) begin
            $error("response with no request outstanding: status %0d tag 0x%02h",
                   rsp_tuser, rsp_tdata);
            faults++;
         end else begin
            want = outcome_fifo.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               faults++;
            end
            if (rsp_tdata !== want.tag) begin
               $error("fired_tag: expected 0x%02h, got 0x%02h", want.tag, rsp_tdata);
               faults++;
            end
         end
      end
   end

   // stop a hung run: too long without any handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_run <= 0;
      else
         quiet_run <= quiet_run + 1;
      if (quiet_run >= QUIET_MAX) begin
         $display("** deadline_sorted_job_timer_queue: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      timer_row_type row;
      logic [31:0]   time_base;
      int            poll_pct;
      int            rep_jobs;
      int            far_jobs;

      // op, now, tag, rep, delay, period, typed, status, fired tag
      opening_rows = '{
         // empty list, poll finds nothing
         '{dsjtq_pkg::OP_POLL, 32'd0, 8'h00, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_NONE_DUE, 8'h00},
         // zero delay job fires at once
         '{dsjtq_pkg::OP_SCHEDULE, 32'd0, 8'hFF, 1'b0, 32'd0, 32'hFFFF_FFFF,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_POLL, 32'd0, 8'h00, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_FIRED, 8'hFF},
         '{dsjtq_pkg::OP_POLL, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_NONE_DUE, 8'h00},
         // repeating job with a saturated deadline and a saturated period
         '{dsjtq_pkg::OP_SCHEDULE, 32'hFFFF_FFFF, 8'hA5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_POLL, 32'hFFFF_FFFE, 8'h00, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_NONE_DUE, 8'h00},
         '{dsjtq_pkg::OP_POLL, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_FIRED, 8'hA5},
         '{dsjtq_pkg::OP_POLL, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_FIRED, 8'hA5},
         // fill the list; equal deadlines land in front of older ones
         '{dsjtq_pkg::OP_SCHEDULE, 32'd100, 8'h01, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd50, 8'h02, 1'b0, 32'd50, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd0, 8'h03, 1'b0, 32'd100, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd100, 8'h04, 1'b0, 32'd5, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd90, 8'h05, 1'b0, 32'd5, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd100, 8'h06, 1'b1, 32'd200, 32'd300,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd0, 8'h07, 1'b0, 32'h8000_0000, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         // sum lands exactly on the top, then one past it
         '{dsjtq_pkg::OP_SCHEDULE, 32'h8000_0000, 8'h08, 1'b0, 32'h7FFF_FFFF, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'h8000_0001, 8'h09, 1'b0, 32'h7FFF_FFFF, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd7, 8'h0A, 1'b0, 32'd3, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd10, 8'h0B, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd120, 8'h0C, 1'b0, 32'd60, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd33, 8'h0D, 1'b0, 32'd1, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd5, 8'h0E, 1'b0, 32'd0, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         '{dsjtq_pkg::OP_SCHEDULE, 32'd150, 8'h0F, 1'b0, 32'd150, 32'd0,
           1'b1, dsjtq_pkg::ST_SCHEDULED, 8'h00},
         // list is full now
         '{dsjtq_pkg::OP_SCHEDULE, 32'd0, 8'h10, 1'b1, 32'd0, 32'd9,
           1'b1, dsjtq_pkg::ST_NO_SLOT, 8'h00},
         // earliest deadline leaves first
         '{dsjtq_pkg::OP_POLL, 32'd100, 8'h00, 1'b0, 32'd0, 32'd0,
           1'b0, dsjtq_pkg::ST_NONE_DUE, 8'h00}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         offer_request(opening_rows[i]);

      // random traffic: time creeps forward like a ms tick, phases lean toward
      // filling or draining the list, the last phase runs with no idling
      time_base = 32'd100;
      for (int phase = 0; phase < PHASES; phase++) begin
         idling   <= (phase < PHASES - 1);
         poll_pct  = (phase == PHASES - 1) ? 50 : ((phase % 2 == 1) ? 70 : 30);
         // hold off until every outstanding response is back
         req_tvalid <= 1'b0;
         do @(posedge clock); while (outcome_fifo.size() != 0);
         for (int n = 0; n < PHASE_LEN; n++) begin
            time_base = time_base + $urandom_range(0, 8);
            rep_jobs  = 0;
            far_jobs  = 0;
            for (int k = 0; k < job_count; k++) begin
               if (job_repeats[deadline_order[k]]) rep_jobs++;
               if (job_deadline[deadline_order[k]] > time_base + 32'h0010_0000) far_jobs++;
            end
            // fields a request ignores still get random bits
            row       = '0;
            row.now   = $urandom;
            row.tag   = 8'($urandom);
            row.rep   = 1'($urandom);
            row.dly   = $urandom;
            row.per   = $urandom;
            if ($urandom_range(1, 100) <= poll_pct) begin
               row.op = dsjtq_pkg::OP_POLL;
               // now and then a poll from an arbitrary point in time
               if ($urandom_range(0, 19) != 0) row.now = time_base;
            end else begin
               row.op = dsjtq_pkg::OP_SCHEDULE;
               // with the list full the request is refused whatever it holds
               if (job_count < MAX_JOBS) begin
                  row.now = time_base;
                  // repeating jobs never give their slot back, so keep them few
                  row.rep = (rep_jobs < 5 && $urandom_range(0, 7) == 0);
                  if (row.rep) row.per = $urandom_range(64, 2000);
                  if (far_jobs < 3 && $urandom_range(0, 24) == 0)
                     row.dly = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom);
                  else
                     row.dly = $urandom_range(0, 120);
               end
            end
            offer_request(row);
         end
      end

      req_tvalid <= 1'b0;
      while (outcome_fifo.size() != 0) @(posedge clock);
      // room for a stray extra response
      repeat (MAX_JOBS + 8) @(posedge clock);
      if (faults == 0)
         $display("** deadline_sorted_job_timer_queue: PASSED **");
      else
         $display("** deadline_sorted_job_timer_queue: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
design/dsjtq_pkg.sv
design/deadline_sorted_job_timer_queue.sv
bench/tb_deadline_sorted_job_timer_queue.sv
